@@ hw/rtl/ascii_frame_validator_defines.svh @@
// Assertion macros shared by the frame validator RTL.
// Each macro expects clk_i and rst_ni in scope at the point of use.
`ifndef ASCII_FRAME_VALIDATOR_DEFINES_SVH
`define ASCII_FRAME_VALIDATOR_DEFINES_SVH

// General implication or condition, checked out of reset
`define AFV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true
`define AFV_ASSERT_NEVER(lbl, cond, msg) \
  `AFV_ASSERT(lbl, !(cond), msg)

`endif

@@ hw/rtl/afv_pkg.sv @@
// Shared types, character constants and the hex digit decoder
// for the ASCII frame validator. No dependencies.
package afv_pkg;

  // Default buffer length limit
  localparam int unsigned MaxBytesDefault = 256;

  // Framing characters
  localparam logic [7:0] CharStart = 8'h24;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharLow   = 8'h21;
  localparam logic [7:0] CharHigh  = 8'h7a;

  // Hex decoding constants
  localparam logic [7:0] HexZero   = 8'd48;
  localparam logic [7:0] HexGap    = 8'd7;
  localparam logic [7:0] HexTen    = 8'd10;

  // Lowest index at which the return may sit
  localparam logic [7:0] MinCrIndex = 8'd9;

  typedef enum logic [1:0] {
    VerdictGood     = 2'd0,
    VerdictNotProto = 2'd1,
    VerdictBadSum   = 2'd2
  } verdict_e;

  // One input item
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } item_t;

  // Evaluation of the item held in the input stage
  typedef struct packed {
    logic       settled;
    verdict_e   verdict;
    logic [7:0] frame_length;
  } check_res_t;

  // Uppercase hex digit, wrapping, no error on non-hex input
  function automatic logic [7:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = c - HexZero;
    if (d >= HexTen) begin
      d = d - HexGap;
    end
    return d;
  endfunction

endpackage

@@ hw/rtl/afv_in_reg.sv @@
// Input register stage of the frame validator.
// Depends on afv_pkg for the item type.
module afv_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  afv_pkg::item_t in_item_i,
  input  logic           advance_i,
  output logic           hold_valid_o,
  output afv_pkg::item_t hold_item_o
);
  import afv_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // Stage takes a new item when empty or when its item moves on
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign hold_valid_o = valid_q;
  assign hold_item_o  = item_q;

endmodule

@@ hw/rtl/afv_check.sv @@
// Frame check logic: per-buffer state and the verdict decision.
// Depends on afv_pkg for types, constants and hex_digit.
module afv_check #(
  parameter int unsigned MaxBytes = afv_pkg::MaxBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  afv_pkg::item_t      item_i,
  input  logic                fire_i,
  output afv_pkg::check_res_t res_o
);
  import afv_pkg::*;

  localparam logic [8:0] LastIndex = 9'(MaxBytes - 1);

  logic [7:0] index_q, index_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] prev_q, prev_d;
  logic [7:0] prev2_q, prev2_d;
  logic       given_q, given_d;

  logic [7:0] pair;
  logic [7:0] hi_digit, lo_digit;
  logic       settled;
  verdict_e   verdict;
  logic [7:0] frame_len;

  // High digit shifted up, low digit OR'd in whole (non-hex input can exceed 15)
  assign hi_digit = hex_digit(prev2_q);
  assign lo_digit = hex_digit(prev_q);
  assign pair     = {hi_digit[3:0], 4'b0000} | lo_digit;

  // Verdict decision for the held item
  always_comb begin
    settled   = 1'b0;
    verdict   = VerdictNotProto;
    frame_len = 8'd0;
    if (!given_q) begin
      if (index_q == 8'd0) begin
        settled = (item_i.rx_byte != CharStart);
      end else if (item_i.rx_byte == CharCr) begin
        settled = 1'b1;
        if (index_q >= MinCrIndex) begin
          verdict   = (pair == sum_q) ? VerdictGood : VerdictBadSum;
          frame_len = index_q;
        end
      end else if (item_i.rx_byte < CharLow || item_i.rx_byte > CharHigh) begin
        settled = 1'b1;
      end
      // length limit or end of buffer without a verdict
      if (!settled && ({1'b0, index_q} >= LastIndex || item_i.end_of_buffer)) begin
        settled = 1'b1;
      end
    end
  end

  // State update on a consumed item
  always_comb begin
    index_d = index_q;
    sum_d   = sum_q;
    prev_d  = prev_q;
    prev2_d = prev2_q;
    given_d = given_q;
    if (fire_i) begin
      if (!given_q && !settled) begin
        sum_d   = sum_q + prev2_q;
        prev2_d = prev_q;
        prev_d  = item_i.rx_byte;
        index_d = index_q + 8'd1;
      end
      if (item_i.end_of_buffer) begin
        index_d = 8'd0;
        sum_d   = 8'd0;
        prev_d  = 8'd0;
        prev2_d = 8'd0;
        given_d = 1'b0;
      end else if (settled) begin
        given_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q <= 8'd0;
      sum_q   <= 8'd0;
      prev_q  <= 8'd0;
      prev2_q <= 8'd0;
      given_q <= 1'b0;
    end else begin
      index_q <= index_d;
      sum_q   <= sum_d;
      prev_q  <= prev_d;
      prev2_q <= prev2_d;
      given_q <= given_d;
    end
  end

  assign res_o.settled      = settled;
  assign res_o.verdict      = verdict;
  assign res_o.frame_length = frame_len;

endmodule

@@ hw/rtl/afv_out_reg.sv @@
// Result register of the frame validator with valid/ready output.
// Depends on afv_pkg for the verdict type.
module afv_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  afv_pkg::verdict_e verdict_i,
  input  logic [7:0]        frame_length_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        verdict_o,
  output logic [7:0]        frame_length_o
);
  import afv_pkg::*;

  logic       valid_q, valid_d;
  verdict_e   verdict_q;
  logic [7:0] len_q;

  // Slot is free when empty or being drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q && !out_ready_i;
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      verdict_q <= verdict_i;
      len_q     <= frame_length_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign verdict_o      = 2'(verdict_q);
  assign frame_length_o = len_q;

endmodule

@@ hw/rtl/ascii_frame_validator.sv @@
// ASCII frame validator: '$'-framed, hex-checksummed UART buffer check.
// Depends on afv_pkg, afv_in_reg, afv_check, afv_out_reg and the defines header.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one received byte per item,
//   rx_byte_i, with end_of_buffer_i set on the last byte of a buffer.
//   Output channel (out_valid_o / out_ready_i) carries at most one verdict per
//   buffer: verdict_o (0 good, 1 not this protocol, 2 checksum mismatch) and
//   frame_length_o (index of the terminating return, 0 for verdict 1).
//   A settling byte is checked while held in the input register and is loaded
//   into the result register when the result slot is free; the load raises
//   out_valid_o.
//   Throughput: one byte per cycle while no settling byte waits on the result
//   slot; per-byte state (index, running sum, last two bytes) updates in afv_check.
//   Bytes that settle nothing pass through without waiting on the output side.
//   A settling byte waits in the input register while an earlier verdict is
//   still unread, so a stalled receiver backs up the input after one item.
//   Reset (rst_ni low, asynchronous) empties both registers and clears the
//   per-buffer state; the next byte is taken as index 0.
module ascii_frame_validator #(
  parameter int unsigned MaxBytes = afv_pkg::MaxBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       end_of_buffer_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] verdict_o,
  output logic [7:0] frame_length_o
);
  import afv_pkg::*;

  `include "ascii_frame_validator_defines.svh"

  item_t      in_item;
  item_t      hold_item;
  logic       hold_valid;
  check_res_t chk_res;
  logic       out_free;
  logic       fire;
  logic       load;

  assign in_item.rx_byte       = rx_byte_i;
  assign in_item.end_of_buffer = end_of_buffer_i;

  // Held item moves on unless it settles while the result slot is busy
  assign fire = hold_valid && (!chk_res.settled || out_free);
  assign load = fire && chk_res.settled;

  afv_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .advance_i   (fire),
    .hold_valid_o(hold_valid),
    .hold_item_o (hold_item)
  );

  afv_check #(
    .MaxBytes(MaxBytes)
  ) u_check (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .item_i(hold_item),
    .fire_i(fire),
    .res_o (chk_res)
  );

  afv_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .verdict_i     (chk_res.verdict),
    .frame_length_i(chk_res.frame_length),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .verdict_o     (verdict_o),
    .frame_length_o(frame_length_o)
  );

  // Checks
  `AFV_ASSERT_NEVER(a_load_busy, load && !out_free, "result loaded over unread verdict")
  `AFV_ASSERT(a_np_len, (out_valid_o && verdict_o == VerdictNotProto) |-> frame_length_o == 8'd0, "not-protocol verdict with nonzero length")
  `AFV_ASSERT(a_frame_len, (out_valid_o && verdict_o != VerdictNotProto) |-> frame_length_o >= MinCrIndex, "frame verdict with short length")
  `AFV_ASSERT(a_load_shows, load |=> out_valid_o, "loaded verdict not presented")

endmodule
